>>> src/fvs_pkg.sv
// Package for the fixed-width and varint serializer.
// Holds opcode codes and the command/status structs between controller and datapath.
// No dependencies.
package fvs_pkg;

	// Opcode codes
	localparam logic [2:0] OP_FIX8    = 3'd0;
	localparam logic [2:0] OP_FIX16   = 3'd1;
	localparam logic [2:0] OP_FIX32   = 3'd2;
	localparam logic [2:0] OP_FIX64   = 3'd3;
	localparam logic [2:0] OP_UVAR32  = 3'd4;
	localparam logic [2:0] OP_ZIGZAG32 = 3'd5;
	localparam logic [2:0] OP_UVAR64  = 3'd6;
	localparam logic [2:0] OP_ZIGZAG64 = 3'd7;

	// Varint byte fields
	localparam logic [7:0] CONT_BIT   = 8'h80;
	localparam logic [6:0] GROUP_MASK = 7'h7F;

	// Controller to datapath
	typedef struct packed {
		logic load;  // capture opcode and value
		logic step;  // emit one byte and advance
	} fvs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;  // byte at the head is the final one
	} fvs_status_t;

endpackage

>>> src/fvs_dp.sv
// Datapath of the serializer: value shift register, byte counter, output registers.
// Depends on fvs_pkg.
module fvs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fvs_pkg::fvs_cmd_t    cmd,
	output fvs_pkg::fvs_status_t status,
	input  logic [2:0]           opcode,
	input  logic [63:0]          value,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	output logic [7:0]           out_byte,
	output logic                 last
);
	import fvs_pkg::*;

	logic        big_endian_q;
	logic [63:0] word_q;
	logic [3:0]  cnt_q;
	logic        varint_q;
	logic        msb_first_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic [63:0] load_word;
	logic [3:0]  load_cnt;
	logic [31:0] lo;
	logic [7:0]  head_byte;
	logic        head_last;

	// Hold the byte-order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (cfg_we) begin
			big_endian_q <= cfg_data;
		end
	end

	// Prepare the word to serialize
	always_comb begin
		lo = value[31:0];
		load_cnt = 4'd0;
		unique case (opcode)
			OP_FIX8: begin
				load_word = big_endian_q ? {value[7:0], 56'd0} : value;
				load_cnt = 4'd1;
			end
			OP_FIX16: begin
				load_word = big_endian_q ? {value[15:0], 48'd0} : value;
				load_cnt = 4'd2;
			end
			OP_FIX32: begin
				load_word = big_endian_q ? {value[31:0], 32'd0} : value;
				load_cnt = 4'd4;
			end
			OP_FIX64: begin
				load_word = value;
				load_cnt = 4'd8;
			end
			OP_UVAR32:   load_word = {32'd0, lo};
			OP_ZIGZAG32: load_word = {32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
			OP_UVAR64:   load_word = value;
			OP_ZIGZAG64: load_word = {value[62:0], 1'b0} ^ {64{value[63]}};
			default:     load_word = value;
		endcase
	end

	// Select the byte at the head of the word
	always_comb begin
		if (varint_q) begin
			head_last = (word_q[63:7] == 57'd0);
			head_byte = {~head_last, word_q[6:0] & GROUP_MASK};
		end else begin
			head_last = (cnt_q == 4'd1);
			head_byte = msb_first_q ? word_q[63:56] : word_q[7:0];
		end
	end

	assign status.last = head_last;

	// Load or advance the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			varint_q    <= 1'b0;
			msb_first_q <= 1'b0;
			cnt_q       <= 4'd0;
		end else if (cmd.load) begin
			varint_q    <= opcode[2];
			msb_first_q <= big_endian_q;
			cnt_q       <= load_cnt;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// Shift register and output registers carry no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= load_word;
		end else if (cmd.step) begin
			if (varint_q) begin
				word_q <= {7'd0, word_q[63:7]};
			end else if (msb_first_q) begin
				word_q <= {word_q[55:0], 8'd0};
			end else begin
				word_q <= {8'd0, word_q[63:8]};
			end
		end
		if (cmd.step) begin
			byte_q <= head_byte | (varint_q && !head_last ? CONT_BIT : 8'd0);
			last_q <= head_last;
		end
	end

	assign out_byte = byte_q;
	assign last     = last_q;

endmodule

>>> src/fvs_ctrl.sv
// Controller of the serializer: idle/emit state machine and the output strobe.
// Depends on fvs_pkg.
module fvs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  fvs_pkg::fvs_status_t status,
	output fvs_pkg::fvs_cmd_t    cmd,
	output logic                 busy,
	output logic                 strobe
);
	import fvs_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   strobe_q;

	// Issue commands from the current state
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.step = (state_q == ST_EMIT);

	// Advance state and register the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (status.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;

`ifndef SYNTH
	a_step_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> strobe)
		else $error("step without strobe");
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy)
		else $error("load did not raise busy");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.last) |=> !busy)
		else $error("still busy after final byte");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load during emit");
`endif

endmodule

>>> src/fixed_and_varint_serializer_unit.sv
// Top level of the fixed-width and varint serializer.
// Depends on fvs_pkg, fvs_ctrl and fvs_dp.
//
// channel   ports                          handshake
// input     opcode, value                  start & !busy
// result    out_byte, last                 strobe, one cycle, no backpressure
// config    cfg_data                       cfg_valid & cfg_ready
//
// An item occupies the unit for its load and then the emission of each of its
// bytes, so a new start is taken only once the previous item is through.
// The single shift register of the datapath is why items cannot overlap.
// Each byte is registered and appears in the cycle after it is shifted out; last marks the final byte.
// Reset returns the unit to idle with big-endian byte order.
// cfg_ready is high while the unit is idle.
module fixed_and_varint_serializer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [63:0] value,
	output logic        strobe,
	output logic [7:0]  out_byte,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import fvs_pkg::*;

	fvs_cmd_t    cmd;
	fvs_status_t status;

	assign cfg_ready = !busy;

	fvs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	fvs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.opcode   (opcode),
		.value    (value),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

>>> tb/tb_fixed_and_varint_serializer_unit.sv
// Self-checking bench for fixed_and_varint_serializer_unit: fixed-width and varint encodings,
// zigzag mapping and both byte orders, with random sender gaps and mid-run config writes.
// Depends on fvs_pkg and the serializer RTL.
module tb_fixed_and_varint_serializer_unit;
	import fvs_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 200;
	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 90;

	typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_kind_t;
	typedef enum logic [2:0] {DRV_IDLE, DRV_GAP, DRV_SEND, DRV_SETTLE, DRV_CFG} drv_state_t;

	typedef struct {
		job_kind_t   kind;
		logic [2:0]  op;
		logic [63:0] val;
		logic        order_bit;
		int          gap;
	} job_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  opcode = OP_FIX8;
	logic [63:0] value = 64'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_data = 1'b0;
	logic        busy;
	logic        strobe;
	logic [7:0]  out_byte;
	logic        last;
	logic        cfg_ready;

	job_t       pending_jobs[$];
	enc_byte_t  expected_bytes[$];
	logic       big_endian_shadow = 1'b1;
	drv_state_t drv_state = DRV_IDLE;
	job_t       cur_job;
	int         gap_left = 0;
	int         settle_count = 0;
	int         item_seq = 0;
	int         cfg_seq = 0;
	int         values_sent = 0;
	int         order_writes = 0;
	int         bytes_checked = 0;
	int         error_count = 0;
	int         idle_cycles = 0;
	bit         no_gaps = 1'b0;

	fixed_and_varint_serializer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.value     (value),
		.strobe    (strobe),
		.out_byte  (out_byte),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Expand one accepted word into the bytes the unit must emit
	function automatic void serialize_value(input logic [2:0] op, input logic [63:0] v,
			input logic msb_first);
		int          nbytes;
		int          idx;
		logic [63:0] group_src;
		enc_byte_t   eb;
		nbytes = 0;
		group_src = 64'd0;
		case (op)
			OP_FIX8:     nbytes = 1;
			OP_FIX16:    nbytes = 2;
			OP_FIX32:    nbytes = 4;
			OP_FIX64:    nbytes = 8;
			OP_UVAR32:   group_src = {32'd0, v[31:0]};
			OP_ZIGZAG32: group_src = {32'd0, {v[30:0], 1'b0} ^ {32{v[31]}}};
			OP_UVAR64:   group_src = v;
			default:     group_src = {v[62:0], 1'b0} ^ {64{v[63]}};
		endcase
		if (nbytes > 0) begin
			for (int i = 0; i < nbytes; i++) begin
				idx = msb_first ? (nbytes - 1 - i) : i;
				eb.data = v[8*idx +: 8];
				eb.last = (i == nbytes - 1);
				expected_bytes = {expected_bytes, eb};
			end
		end else begin
			// base-128 groups, low group first, continuation on all but the final byte
			while (group_src >= 64'(CONT_BIT)) begin
				eb.data = CONT_BIT | {1'b0, group_src[6:0] & GROUP_MASK};
				eb.last = 1'b0;
				expected_bytes = {expected_bytes, eb};
				group_src = group_src >> 7;
			end
			eb.data = group_src[7:0];
			eb.last = 1'b1;
			expected_bytes = {expected_bytes, eb};
		end
	endfunction

	// Mix of full-width noise, small values, powers of two or one below, small negatives and sign-extended 32-bit words
	function automatic logic [63:0] pick_value();
		int          k;
		logic [31:0] r;
		logic [63:0] v;
		case ($urandom_range(0, 4))
			0: v = {$urandom(), $urandom()};
			1: v = 64'($urandom_range(0, 300));
			2: begin
				k = $urandom_range(0, 63);
				v = 64'd1 << k;
				if ($urandom_range(0, 1))
					v = v - 64'd1;
			end
			3: v = 64'd0 - 64'($urandom_range(1, 300));
			default: begin
				r = $urandom();
				v = {{32{r[31]}}, r};
			end
		endcase
		return v;
	endfunction

	task automatic add_item(input logic [2:0] op, input logic [63:0] v);
		job_t j;
		j.kind = JOB_ITEM;
		j.op = op;
		j.val = v;
		j.order_bit = 1'b0;
		j.gap = (!no_gaps && $urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
		pending_jobs = {pending_jobs, j};
	endtask

	task automatic add_order_write(input logic msb_first);
		job_t j;
		j.kind = JOB_CFG;
		j.op = OP_FIX8;
		j.val = 64'd0;
		j.order_bit = msb_first;
		j.gap = 0;
		pending_jobs = {pending_jobs, j};
	endtask

	task automatic add_drain();
		job_t j;
		j.kind = JOB_DRAIN;
		j.op = OP_FIX8;
		j.val = 64'd0;
		j.order_bit = 1'b0;
		j.gap = 0;
		pending_jobs = {pending_jobs, j};
	endtask

	// Driver: advance through the job queue at the falling edge
	always @(negedge clk) begin
		logic        nxt_start;
		logic        nxt_cfg_valid;
		logic        nxt_cfg_data;
		logic [2:0]  nxt_op;
		logic [63:0] nxt_val;
		bit          grab;
		nxt_start = start;
		nxt_cfg_valid = cfg_valid;
		nxt_cfg_data = cfg_data;
		nxt_op = opcode;
		nxt_val = value;
		grab = 1'b0;
		if (arst_n) begin
			case (drv_state)
				DRV_IDLE: grab = 1'b1;
				DRV_GAP: begin
					gap_left--;
					if (gap_left == 0) begin
						nxt_start = 1'b1;
						nxt_op = cur_job.op;
						nxt_val = cur_job.val;
						item_seq = values_sent + 1;
						drv_state = DRV_SEND;
					end
				end
				DRV_SEND: begin
					if (values_sent == item_seq) begin
						nxt_start = 1'b0;
						grab = 1'b1;
					end
				end
				DRV_SETTLE: begin
					// hold until every expected byte is out and the unit has gone quiet
					if (expected_bytes.size() == 0 && !busy && !strobe)
						settle_count++;
					else
						settle_count = 0;
					if (settle_count >= SETTLE_CYCLES) begin
						if (cur_job.kind == JOB_CFG) begin
							nxt_cfg_valid = 1'b1;
							nxt_cfg_data = cur_job.order_bit;
							cfg_seq = order_writes + 1;
							drv_state = DRV_CFG;
						end else begin
							grab = 1'b1;
						end
					end
				end
				DRV_CFG: begin
					if (order_writes == cfg_seq) begin
						nxt_cfg_valid = 1'b0;
						grab = 1'b1;
					end
				end
				default: grab = 1'b1;
			endcase
			if (grab) begin
				if (pending_jobs.size() == 0) begin
					drv_state = DRV_IDLE;
				end else begin
					cur_job = pending_jobs.pop_front();
					if (cur_job.kind != JOB_ITEM) begin
						settle_count = 0;
						drv_state = DRV_SETTLE;
					end else if (cur_job.gap > 0) begin
						nxt_start = 1'b0;
						gap_left = cur_job.gap;
						drv_state = DRV_GAP;
					end else begin
						nxt_start = 1'b1;
						nxt_op = cur_job.op;
						nxt_val = cur_job.val;
						item_seq = values_sent + 1;
						drv_state = DRV_SEND;
					end
				end
			end
		end
		start <= nxt_start;
		cfg_valid <= nxt_cfg_valid;
		cfg_data <= nxt_cfg_data;
		opcode <= nxt_op;
		value <= nxt_val;
	end

	// Monitor: predict on accepted words, check each strobed byte, watch for a hang
	always @(posedge clk) begin
		bit        active;
		enc_byte_t want;
		active = 1'b0;
		if (arst_n) begin
			if (strobe) begin
				active = 1'b1;
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte: out_byte=%02h last=%0b", out_byte, last);
					error_count++;
				end else begin
					want = expected_bytes.pop_front();
					bytes_checked++;
					if (out_byte !== want.data) begin
						$error("out_byte mismatch: expected %02h actual %02h", want.data, out_byte);
						error_count++;
					end
					if (last !== want.last) begin
						$error("last mismatch: expected %0b actual %0b", want.last, last);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				serialize_value(opcode, value, big_endian_shadow);
				values_sent++;
				active = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				big_endian_shadow = cfg_data;
				order_writes++;
				active = 1'b1;
			end
			idle_cycles = active ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		// Directed words under the reset byte order (most significant first)
		add_item(OP_FIX8, 64'hDEAD_BEEF_CAFE_F0A5);
		add_item(OP_FIX16, 64'hDEAD_BEEF_CAFE_F0A5);
		add_item(OP_FIX32, 64'hDEAD_BEEF_CAFE_F0A5);
		add_item(OP_FIX64, 64'h0123_4567_89AB_CDEF);
		add_item(OP_FIX64, '1);
		add_item(OP_FIX64, 64'd0);
		add_item(OP_UVAR32, 64'd0);
		add_item(OP_UVAR32, 64'h7F);
		add_item(OP_UVAR32, 64'h80);
		add_item(OP_UVAR32, 64'hFFFF_FFFF_0000_0080);
		add_item(OP_UVAR32, 64'h0000_0000_FFFF_FFFF);
		add_item(OP_ZIGZAG32, 64'd0);
		add_item(OP_ZIGZAG32, 64'h0000_0000_FFFF_FFFF);
		add_item(OP_ZIGZAG32, 64'h0000_0000_8000_0000);
		add_item(OP_ZIGZAG32, 64'hFFFF_FFFF_7FFF_FFFF);
		add_item(OP_UVAR64, 64'h7F);
		add_item(OP_UVAR64, '1);
		add_item(OP_UVAR64, 64'h8000_0000_0000_0000);
		add_item(OP_ZIGZAG64, '1);
		add_item(OP_ZIGZAG64, 64'h8000_0000_0000_0000);
		add_item(OP_ZIGZAG64, 64'h7FFF_FFFF_FFFF_FFFF);
		add_item(OP_ZIGZAG64, 64'd1);
		// Flip to least significant first and repeat the 16-, 32- and 64-bit fixed widths
		add_order_write(1'b0);
		add_item(OP_FIX16, 64'hDEAD_BEEF_CAFE_F0A5);
		add_item(OP_FIX32, 64'hDEAD_BEEF_CAFE_F0A5);
		add_item(OP_FIX64, 64'h0123_4567_89AB_CDEF);
		add_order_write(1'b1);

		// Random phases, each under its own byte order; the last phase runs without gaps
		for (int p = 0; p < PHASES; p++) begin
			no_gaps = (p == PHASES - 1);
			add_order_write(p == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					add_drain();
				add_item(3'($urandom_range(0, 7)), pick_value());
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(pending_jobs.size() == 0 && drv_state == DRV_IDLE &&
				expected_bytes.size() == 0))
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (expected_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_bytes.size());
			error_count++;
		end
		$display("covered %0d values over all eight opcodes, %0d bytes checked",
			values_sent, bytes_checked);
		$display("byte order rewritten %0d times, %0d mismatches", order_writes, error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
